// ----- rtl/babybear_ntt_butterfly_alu_core_macros.svh -----
// Assertion macros shared by the BabyBear arithmetic core.
`ifndef BABYBEAR_NTT_BUTTERFLY_ALU_CORE_MACROS_SVH
`define BABYBEAR_NTT_BUTTERFLY_ALU_CORE_MACROS_SVH

// Check a plain property on the rising clock edge, off while in reset.
`define BBNTT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BBNTT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bbntt_pkg.sv -----
// Types, constants and field helpers for the BabyBear arithmetic core.
package bbntt_pkg;

  localparam int unsigned WordW = 31;
  localparam int unsigned ExtW  = WordW + 1;
  localparam int unsigned RedW  = 32;
  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned PhW   = ProdW - RedW;
  localparam int unsigned QpW   = RedW + WordW;
  localparam int unsigned LatCycles = 6;

  localparam logic [ExtW-1:0] Modulus = 32'd2013265921;
  localparam logic [RedW-1:0] MontInv = 32'd2281701377;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    OP_BFLY = 2'd0,
    OP_MMUL = 2'd1,
    OP_ADD  = 2'd2,
    OP_SUB  = 2'd3
  } op_e;

  typedef struct packed {
    op_e   op;
    word_t a;
    word_t b;
    logic  last;
  } side_t;

  // Fold any 31-bit value into [0, p): one subtract suffices as 2^31 - 1 < 2p.
  function automatic word_t canon(word_t v);
    logic [ExtW-1:0] w;
    w = {1'b0, v};
    if (w >= Modulus) begin
      w = w - Modulus;
    end
    return w[WordW-1:0];
  endfunction

  function automatic word_t mod_add(word_t a, word_t b);
    logic [ExtW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= Modulus) begin
      s = s - Modulus;
    end
    return s[WordW-1:0];
  endfunction

  function automatic word_t mod_sub(word_t a, word_t b);
    logic [ExtW-1:0] d;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + Modulus - {1'b0, b};
    end
    return d[WordW-1:0];
  endfunction

endpackage

// ----- rtl/bbntt_front.sv -----
// Input stage: fold operands to canonical form and pick the multiplier operands.
module bbntt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           req_type_i,
  input  bbntt_pkg::word_t     op_a_i,
  input  bbntt_pkg::word_t     op_b_i,
  input  bbntt_pkg::word_t     twiddle_i,
  input  logic                 last_in_i,
  output logic                 valid_o,
  output bbntt_pkg::word_t     mul_x_o,
  output bbntt_pkg::word_t     mul_y_o,
  output bbntt_pkg::side_t     side_o
);
  import bbntt_pkg::*;

  word_t a_c, b_c, tw_c;
  op_e   op_c;
  logic  valid_q;
  word_t x_d, y_d, x_q, y_q;
  side_t side_d, side_q;

  always_comb begin
    a_c  = canon(op_a_i);
    b_c  = canon(op_b_i);
    tw_c = canon(twiddle_i);
    op_c = op_e'(req_type_i);
    // butterfly multiplies b by the twiddle, Montgomery multiply takes a by b
    if (op_c == OP_BFLY) begin
      x_d = b_c;
      y_d = tw_c;
    end else begin
      x_d = a_c;
      y_d = b_c;
    end
    side_d.op   = op_c;
    side_d.a    = a_c;
    side_d.b    = b_c;
    side_d.last = last_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign mul_x_o = x_q;
  assign mul_y_o = y_q;
  assign side_o  = side_q;

endmodule

// ----- rtl/bbntt_mont.sv -----
// Four-stage Montgomery multiplier: product, quotient, quotient times p, fix-up.
`include "babybear_ntt_butterfly_alu_core_macros.svh"

module bbntt_mont (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  bbntt_pkg::word_t     mul_x_i,
  input  bbntt_pkg::word_t     mul_y_i,
  input  bbntt_pkg::side_t     side_i,
  output logic                 valid_o,
  output bbntt_pkg::word_t     t_o,
  output bbntt_pkg::side_t     side_o
);
  import bbntt_pkg::*;

  logic [3:0] valid_q;
  side_t      side1_q, side2_q, side3_q, side4_q;

  logic [ProdW-1:0] prod_q;
  logic [RedW-1:0]  q_d, q_q;
  logic [PhW-1:0]   ph2_q, ph3_q;
  logic [QpW-1:0]   qp;
  word_t            qh_q;
  word_t            t_d, t_q;

  always_comb begin
    // only the low half of the product feeds the quotient
    q_d = prod_q[RedW-1:0] * MontInv;
    qp  = QpW'(q_q) * QpW'(Modulus[WordW-1:0]);
    // low halves of prod and q*p cancel, leaving the high-half difference
    t_d = mod_sub(WordW'(ph3_q), qh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= ProdW'(mul_x_i) * ProdW'(mul_y_i);
    side1_q <= side_i;
    q_q     <= q_d;
    ph2_q   <= prod_q[ProdW-1:RedW];
    side2_q <= side1_q;
    qh_q    <= qp[QpW-1:RedW];
    ph3_q   <= ph2_q;
    side3_q <= side2_q;
    t_q     <= t_d;
    side4_q <= side3_q;
  end

  assign valid_o = valid_q[3];
  assign t_o     = t_q;
  assign side_o  = side4_q;

  `BBNTT_ASSERT_IMP(a_mont_canon, clk_i, rst_ni, valid_o, ({1'b0, t_o} < Modulus),
                    "Montgomery product not below p")
  `BBNTT_ASSERT_IMP(a_mont_fill, clk_i, rst_ni, valid_o, $past(valid_i, 4),
                    "Montgomery result without an entering beat")

endmodule

// ----- rtl/bbntt_post.sv -----
// Output stage: combine the Montgomery result with a, pass it on, or do plain add and subtract.
module bbntt_post (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  bbntt_pkg::word_t     t_i,
  input  bbntt_pkg::side_t     side_i,
  output logic                 res_valid_o,
  output bbntt_pkg::word_t     res_first_o,
  output bbntt_pkg::word_t     res_second_o,
  output logic                 last_out_o
);
  import bbntt_pkg::*;

  logic  valid_q;
  word_t first_d, second_d, first_q, second_q;
  logic  last_q;

  always_comb begin
    second_d = '0;
    case (side_i.op)
      OP_BFLY: begin
        first_d  = mod_add(side_i.a, t_i);
        second_d = mod_sub(side_i.a, t_i);
      end
      OP_MMUL: begin
        first_d = t_i;
      end
      OP_ADD: begin
        first_d = mod_add(side_i.a, side_i.b);
      end
      OP_SUB: begin
        first_d = mod_sub(side_i.a, side_i.b);
      end
      default: begin
        first_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    last_q   <= side_i.last;
  end

  assign res_valid_o  = valid_q;
  assign res_first_o  = first_q;
  assign res_second_o = second_q;
  assign last_out_o   = last_q;

endmodule

// ----- rtl/babybear_ntt_butterfly_alu_core.sv -----
// Top level of the BabyBear butterfly and field arithmetic core.
//
//   channel   handshake                  payload
//   request   start_i, busy_o            req_type_i, op_a_i, op_b_i, twiddle_i, last_in_i
//   result    res_valid_o (one cycle)    res_first_o, res_second_o, last_out_o
//
// A beat may enter every cycle.
// The depth is set by the Montgomery multiplier: product, quotient, quotient
// times p and fix-up each take one register stage, between an input and an
// output stage. busy_o stays low: nothing stalls inside the pipeline, and the
// receiver cannot hold a result off.
// Reset clears the valid bits only; no beat is in flight afterwards.
`include "babybear_ntt_butterfly_alu_core_macros.svh"

module babybear_ntt_butterfly_alu_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           req_type_i,
  input  bbntt_pkg::word_t     op_a_i,
  input  bbntt_pkg::word_t     op_b_i,
  input  bbntt_pkg::word_t     twiddle_i,
  input  logic                 last_in_i,
  output logic                 res_valid_o,
  output bbntt_pkg::word_t     res_first_o,
  output bbntt_pkg::word_t     res_second_o,
  output logic                 last_out_o
);
  import bbntt_pkg::*;

  logic  front_valid, mont_valid;
  word_t mul_x, mul_y, mont_t;
  side_t front_side, mont_side;

  assign busy_o = 1'b0;

  bbntt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .op_a_i     (op_a_i),
    .op_b_i     (op_b_i),
    .twiddle_i  (twiddle_i),
    .last_in_i  (last_in_i),
    .valid_o    (front_valid),
    .mul_x_o    (mul_x),
    .mul_y_o    (mul_y),
    .side_o     (front_side)
  );

  bbntt_mont u_mont (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .mul_x_i (mul_x),
    .mul_y_i (mul_y),
    .side_i  (front_side),
    .valid_o (mont_valid),
    .t_o     (mont_t),
    .side_o  (mont_side)
  );

  bbntt_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (mont_valid),
    .t_i          (mont_t),
    .side_i       (mont_side),
    .res_valid_o  (res_valid_o),
    .res_first_o  (res_first_o),
    .res_second_o (res_second_o),
    .last_out_o   (last_out_o)
  );

  `BBNTT_ASSERT_IMP(a_res_canon, clk_i, rst_ni, res_valid_o,
                    (({1'b0, res_first_o} < Modulus) && ({1'b0, res_second_o} < Modulus)),
                    "result not a canonical residue")
  `BBNTT_ASSERT_IMP(a_res_sourced, clk_i, rst_ni, res_valid_o, $past(start_i, LatCycles),
                    "result beat without a request")
  `BBNTT_ASSERT(a_req_delivered, clk_i, rst_ni, start_i |-> ##LatCycles res_valid_o,
                "request beat lost in the pipeline")

endmodule

// ----- dv/babybear_ntt_butterfly_alu_core_checker.sv -----
// Checker for the BabyBear arithmetic core: predicts each beat's result and compares it.
`timescale 1ns / 100ps

module babybear_ntt_butterfly_alu_core_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        req_type_i,
  input  bbntt_pkg::word_t  op_a_i,
  input  bbntt_pkg::word_t  op_b_i,
  input  bbntt_pkg::word_t  twiddle_i,
  input  logic              last_in_i,
  input  logic              res_valid_i,
  input  bbntt_pkg::word_t  res_first_i,
  input  bbntt_pkg::word_t  res_second_i,
  input  logic              last_out_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       outstanding_o
);
  import bbntt_pkg::*;

  localparam logic [31:0] FieldP    = 32'd2013265921;
  localparam logic [31:0] FieldPInv = 32'd2281701377;

  typedef struct packed {
    word_t first;
    word_t second;
    logic  last;
  } field_result_t;

  field_result_t awaited_results[$];
  int unsigned   fail_tally = 0;

  // Any 31-bit value is below 2p, so one subtraction makes it canonical.
  function automatic logic [31:0] fold_p(input word_t v);
    logic [31:0] x;
    x = {1'b0, v};
    if (x >= FieldP) begin
      x = x - FieldP;
    end
    return x;
  endfunction

  function automatic logic [31:0] add_modp(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if (s >= FieldP) begin
      s = s - FieldP;
    end
    return s;
  endfunction

  function automatic logic [31:0] sub_modp(input logic [31:0] a, input logic [31:0] b);
    if (a >= b) begin
      return a - b;
    end
    return a + FieldP - b;
  endfunction

  // a*b*2^-32 mod p; the low halves of the product and q*p cancel.
  function automatic logic [31:0] mont_product(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    logic [63:0] qp;
    logic [31:0] q;
    logic [31:0] ph;
    logic [31:0] qh;
    prod = {32'd0, a} * {32'd0, b};
    q    = prod[31:0] * FieldPInv;
    qp   = {32'd0, q} * {32'd0, FieldP};
    ph   = prod[63:32];
    qh   = qp[63:32];
    if (ph >= qh) begin
      return ph - qh;
    end
    return ph + FieldP - qh;
  endfunction

  function automatic field_result_t field_alu_result(input op_e op, input word_t a_raw,
                                                     input word_t b_raw, input word_t tw_raw,
                                                     input logic last);
    field_result_t r;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   t;
    a        = fold_p(a_raw);
    b        = fold_p(b_raw);
    r.second = '0;
    r.last   = last;
    case (op)
      OP_BFLY: begin
        t        = mont_product(b, fold_p(tw_raw));
        r.first  = word_t'(add_modp(a, t));
        r.second = word_t'(sub_modp(a, t));
      end
      OP_MMUL: r.first = word_t'(mont_product(a, b));
      OP_ADD:  r.first = word_t'(add_modp(a, b));
      default: r.first = word_t'(sub_modp(a, b));
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    field_result_t want;
    if (!rst_ni) begin
      awaited_results.delete();
    end else begin
      if (res_valid_i) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing awaited: first %0d second %0d last %0b",
                 res_first_i, res_second_i, last_out_i);
          fail_tally++;
        end else begin
          want = awaited_results.pop_front();
          if (res_first_i !== want.first) begin
            $error("res_first_o: expected %0d, actual %0d", want.first, res_first_i);
            fail_tally++;
          end
          if (res_second_i !== want.second) begin
            $error("res_second_o: expected %0d, actual %0d", want.second, res_second_i);
            fail_tally++;
          end
          if (last_out_i !== want.last) begin
            $error("last_out_o: expected %0b, actual %0b", want.last, last_out_i);
            fail_tally++;
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_results.push_back(field_alu_result(op_e'(req_type_i), op_a_i, op_b_i,
                                                   twiddle_i, last_in_i));
      end
    end
    mismatch_count_o = fail_tally;
    outstanding_o    = awaited_results.size();
  end

endmodule

// ----- dv/tb_babybear_ntt_butterfly_alu_core.sv -----
// Testbench top for the BabyBear arithmetic core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_babybear_ntt_butterfly_alu_core;
  import bbntt_pkg::*;

  localparam word_t       PMinus1    = 31'd2013265920;
  localparam word_t       PExact     = 31'd2013265921;
  localparam word_t       AllOnes    = 31'h7FFF_FFFF;
  localparam word_t       MontOne    = 31'd268435454;
  localparam int unsigned RandBeats  = 500;
  localparam int unsigned CycleLimit = 200000;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [1:0]       req_type_i   = '0;
  word_t            op_a_i       = '0;
  word_t            op_b_i       = '0;
  word_t            twiddle_i    = '0;
  logic             last_in_i    = 1'b0;
  logic             busy_o;
  logic             res_valid_o;
  word_t            res_first_o;
  word_t            res_second_o;
  logic             last_out_o;
  int unsigned      mismatch_count;
  int unsigned      outstanding;
  int unsigned      cycle_count  = 0;

  always #1 clk_i = ~clk_i;

  babybear_ntt_butterfly_alu_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .op_a_i      (op_a_i),
    .op_b_i      (op_b_i),
    .twiddle_i   (twiddle_i),
    .last_in_i   (last_in_i),
    .res_valid_o (res_valid_o),
    .res_first_o (res_first_o),
    .res_second_o(res_second_o),
    .last_out_o  (last_out_o)
  );

  babybear_ntt_butterfly_alu_core_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .req_type_i      (req_type_i),
    .op_a_i          (op_a_i),
    .op_b_i          (op_b_i),
    .twiddle_i       (twiddle_i),
    .last_in_i       (last_in_i),
    .res_valid_i     (res_valid_o),
    .res_first_i     (res_first_o),
    .res_second_i    (res_second_o),
    .last_out_i      (last_out_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly canonical values, with the odd extreme and the odd value at or above p.
  function automatic word_t pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return word_t'($urandom_range(32'd2013265921, 32'h7FFF_FFFF));
      1:       return ($urandom_range(0, 1) != 0) ? PMinus1 : word_t'($urandom_range(0, 1));
      default: return word_t'($urandom_range(0, 32'd2013265920));
    endcase
  endfunction

  // Idle for a random run of cycles, then offer one beat and hold it until taken.
  task automatic offer_beat(input op_e op, input word_t a, input word_t b, input word_t tw,
                            input logic last, input int unsigned idle_pct);
    int unsigned idle;
    idle = 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      idle++;
    end
    if (idle != 0) begin
      start_i   <= 1'b0;
      op_a_i    <= word_t'($urandom);
      twiddle_i <= word_t'($urandom);
      repeat (idle) @(posedge clk_i);
    end
    req_type_i <= op;
    op_a_i     <= a;
    op_b_i     <= b;
    twiddle_i  <= tw;
    last_in_i  <= last;
    start_i    <= 1'b1;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned idle_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, operands at or above p, ignored twiddle, wrap-arounds.
    offer_beat(OP_BFLY, '0,      '0,      '0,      1'b0, 0);
    offer_beat(OP_BFLY, PMinus1, PMinus1, PMinus1, 1'b1, 0);
    offer_beat(OP_BFLY, '0,      PMinus1, 31'd1,   1'b0, 0);
    offer_beat(OP_BFLY, AllOnes, PExact,  AllOnes, 1'b1, 0);
    offer_beat(OP_BFLY, PExact,  31'd1,   PMinus1, 1'b0, 0);
    offer_beat(OP_BFLY, 31'd5,   31'd7,   MontOne, 1'b1, 0);
    offer_beat(OP_MMUL, '0,      '0,      AllOnes, 1'b0, 0);
    offer_beat(OP_MMUL, PMinus1, PMinus1, '0,      1'b1, 0);
    offer_beat(OP_MMUL, AllOnes, AllOnes, PMinus1, 1'b0, 0);
    offer_beat(OP_MMUL, 31'd1,   31'd1,   31'd3,   1'b1, 0);
    offer_beat(OP_ADD,  PMinus1, PMinus1, AllOnes, 1'b0, 0);
    offer_beat(OP_ADD,  '0,      '0,      31'd9,   1'b1, 0);
    offer_beat(OP_ADD,  AllOnes, PExact,  '0,      1'b0, 0);
    offer_beat(OP_ADD,  PMinus1, 31'd1,   PMinus1, 1'b1, 0);
    offer_beat(OP_SUB,  '0,      PMinus1, AllOnes, 1'b0, 0);
    offer_beat(OP_SUB,  PMinus1, '0,      '0,      1'b1, 0);
    offer_beat(OP_SUB,  31'd5,   31'd5,   31'd5,   1'b0, 0);
    offer_beat(OP_SUB,  PExact,  AllOnes, PExact,  1'b1, 0);

    // Idle 12% of the time, then 65%, then not at all.
    for (int unsigned i = 0; i < RandBeats; i++) begin
      if (i < RandBeats / 3) begin
        idle_pct = 12;
      end else if (i < 2 * RandBeats / 3) begin
        idle_pct = 65;
      end else begin
        idle_pct = 0;
      end
      offer_beat(op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(), pick_operand(),
                 1'($urandom_range(0, 1)), idle_pct);
    end
    start_i <= 1'b0;

    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (LatCycles + 4) @(posedge clk_i);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
